[rtl/attack_stage_correlator_macros.svh]
// Assertion macros for the attack stage correlator; empty bodies under synthesis.
`ifndef ATTACK_STAGE_CORRELATOR_MACROS_SVH
`define ATTACK_STAGE_CORRELATOR_MACROS_SVH
`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define AST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("attack_stage_correlator: same-cycle check failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define AST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("attack_stage_correlator: next-cycle check failed");
`else
`define AST_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define AST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/ast_pkg.sv]
// Shared types, codes and lookup functions for the attack stage correlator.
`default_nettype none
package ast_pkg;

	localparam int KIND_W  = 4;
	localparam int NOW_W   = 32;
	localparam int STAGE_W = 3;
	localparam int SCORE_W = 7;
	localparam int SEEN_W  = 3;
	localparam int TAG_W   = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Stage codes.
	localparam logic [STAGE_W-1:0] STAGE_IDLE     = 3'd0;
	localparam logic [STAGE_W-1:0] STAGE_RECON    = 3'd1;
	localparam logic [STAGE_W-1:0] STAGE_EXPLOIT  = 3'd2;
	localparam logic [STAGE_W-1:0] STAGE_EXFIL    = 3'd3;
	localparam logic [STAGE_W-1:0] STAGE_COMPLETE = 3'd4;

	// Attack kind codes.
	localparam logic [KIND_W-1:0] KIND_NONE      = 4'd0;
	localparam logic [KIND_W-1:0] KIND_PORT_SCAN = 4'd1;
	localparam logic [KIND_W-1:0] KIND_NULL_SCAN = 4'd2;
	localparam logic [KIND_W-1:0] KIND_XMAS_SCAN = 4'd3;
	localparam logic [KIND_W-1:0] KIND_SYNFIN    = 4'd4;
	localparam logic [KIND_W-1:0] KIND_ARP_SPOOF = 4'd5;
	localparam logic [KIND_W-1:0] KIND_SYN_FLOOD = 4'd6;
	localparam logic [KIND_W-1:0] KIND_BRUTE     = 4'd7;
	localparam logic [KIND_W-1:0] KIND_DNS_TUN   = 4'd8;
	localparam logic [KIND_W-1:0] KIND_AMPLIFY   = 4'd9;
	localparam logic [KIND_W-1:0] KIND_ICMP_FLD  = 4'd10;

	// Technique tag bits.
	localparam logic [TAG_W-1:0] TAG_NET_SCAN  = 5'b00001;
	localparam logic [TAG_W-1:0] TAG_MITM      = 5'b00010;
	localparam logic [TAG_W-1:0] TAG_DOS       = 5'b00100;
	localparam logic [TAG_W-1:0] TAG_BRUTE     = 5'b01000;
	localparam logic [TAG_W-1:0] TAG_DNS_EXFIL = 5'b10000;

	localparam logic [SEEN_W-1:0]  ALL_STAGES_SEEN = 3'b111;
	localparam logic [SCORE_W-1:0] SCORE_CAP       = 7'd100;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECON    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPLOIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EXFIL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPLETE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BONUS    = 3'd6;

	// Configuration reset values.
	localparam logic [15:0]        RST_WINDOW   = 16'd1800;
	localparam logic [15:0]        RST_FAST     = 16'd300;
	localparam logic [SCORE_W-1:0] RST_RECON    = 7'd20;
	localparam logic [SCORE_W-1:0] RST_EXPLOIT  = 7'd50;
	localparam logic [SCORE_W-1:0] RST_EXFIL    = 7'd70;
	localparam logic [SCORE_W-1:0] RST_COMPLETE = 7'd90;
	localparam logic [SCORE_W-1:0] RST_BONUS    = 7'd10;

	typedef struct packed {
		logic [15:0]        window_seconds;
		logic [15:0]        fast_seconds;
		logic [SCORE_W-1:0] score_recon;
		logic [SCORE_W-1:0] score_exploit;
		logic [SCORE_W-1:0] score_exfil;
		logic [SCORE_W-1:0] score_complete;
		logic [SCORE_W-1:0] speed_bonus;
	} cfg_t;

	typedef struct packed {
		logic [STAGE_W-1:0] stage;
		logic [SCORE_W-1:0] severity;
		logic [SEEN_W-1:0]  stages_seen;
		logic [TAG_W-1:0]   technique_tags;
	} res_t;

	function automatic logic [STAGE_W-1:0] kind_stage(input logic [KIND_W-1:0] kind);
		logic [STAGE_W-1:0] st;
		unique case (kind)
			KIND_PORT_SCAN, KIND_NULL_SCAN, KIND_XMAS_SCAN, KIND_SYNFIN,
			KIND_ARP_SPOOF:                          st = STAGE_RECON;
			KIND_SYN_FLOOD, KIND_BRUTE:              st = STAGE_EXPLOIT;
			KIND_DNS_TUN, KIND_AMPLIFY, KIND_ICMP_FLD: st = STAGE_EXFIL;
			default:                                 st = STAGE_IDLE;
		endcase
		return st;
	endfunction

	function automatic logic [TAG_W-1:0] kind_tag(input logic [KIND_W-1:0] kind);
		logic [TAG_W-1:0] tg;
		unique case (kind)
			KIND_PORT_SCAN, KIND_NULL_SCAN, KIND_XMAS_SCAN, KIND_SYNFIN:
				tg = TAG_NET_SCAN;
			KIND_ARP_SPOOF:                              tg = TAG_MITM;
			KIND_SYN_FLOOD, KIND_AMPLIFY, KIND_ICMP_FLD: tg = TAG_DOS;
			KIND_BRUTE:                                  tg = TAG_BRUTE;
			KIND_DNS_TUN:                                tg = TAG_DNS_EXFIL;
			default:                                     tg = '0;
		endcase
		return tg;
	endfunction

endpackage
`default_nettype wire

[rtl/ast_if.sv]
// Valid/ready channel interfaces for detection words in and incident words out.
`default_nettype none
interface ast_in_if;
	logic                         valid;
	logic                         ready;
	logic [ast_pkg::KIND_W-1:0]   attack_kind;
	logic [ast_pkg::NOW_W-1:0]    now_seconds;

	modport source (output valid, attack_kind, now_seconds, input ready);
	modport sink (input valid, attack_kind, now_seconds, output ready);
endinterface

interface ast_out_if;
	logic                         valid;
	logic                         ready;
	logic [ast_pkg::STAGE_W-1:0]  stage;
	logic [ast_pkg::SCORE_W-1:0]  severity;
	logic [ast_pkg::SEEN_W-1:0]   stages_seen;
	logic [ast_pkg::TAG_W-1:0]    technique_tags;

	modport source (output valid, stage, severity, stages_seen, technique_tags, input ready);
	modport sink (input valid, stage, severity, stages_seen, technique_tags, output ready);
endinterface
`default_nettype wire

[rtl/ast_cfg_regs.sv]
// Configuration register file of the attack stage correlator.
`default_nettype none
module ast_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [ast_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ast_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output      ast_pkg::cfg_t                      cfg
);

	ast_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_seconds <= ast_pkg::RST_WINDOW;
			cfg_q.fast_seconds   <= ast_pkg::RST_FAST;
			cfg_q.score_recon    <= ast_pkg::RST_RECON;
			cfg_q.score_exploit  <= ast_pkg::RST_EXPLOIT;
			cfg_q.score_exfil    <= ast_pkg::RST_EXFIL;
			cfg_q.score_complete <= ast_pkg::RST_COMPLETE;
			cfg_q.speed_bonus    <= ast_pkg::RST_BONUS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ast_pkg::CFG_WINDOW:   cfg_q.window_seconds <= cfg_wdata;
				ast_pkg::CFG_FAST:     cfg_q.fast_seconds   <= cfg_wdata;
				ast_pkg::CFG_RECON:    cfg_q.score_recon    <= cfg_wdata[ast_pkg::SCORE_W-1:0];
				ast_pkg::CFG_EXPLOIT:  cfg_q.score_exploit  <= cfg_wdata[ast_pkg::SCORE_W-1:0];
				ast_pkg::CFG_EXFIL:    cfg_q.score_exfil    <= cfg_wdata[ast_pkg::SCORE_W-1:0];
				ast_pkg::CFG_COMPLETE: cfg_q.score_complete <= cfg_wdata[ast_pkg::SCORE_W-1:0];
				ast_pkg::CFG_BONUS:    cfg_q.speed_bonus    <= cfg_wdata[ast_pkg::SCORE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[rtl/ast_core.sv]
// Incident state registers and the combinational update for one detection word.
`default_nettype none
module ast_core #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire logic [ast_pkg::KIND_W-1:0]     kind,
	input  wire logic [ast_pkg::NOW_W-1:0]      now_raw,
	input  wire ast_pkg::cfg_t                  cfg,
	output      ast_pkg::res_t                  res
);

	logic [TIME_BITS-1:0]          now;
	logic [ast_pkg::STAGE_W-1:0]   stage_q, stage_d;
	logic [TIME_BITS-1:0]          entry_q, entry_d;
	logic [TIME_BITS-1:0]          first_q, first_d;
	logic                          first_vld_q, first_vld_d;
	logic [ast_pkg::SEEN_W-1:0]    seen_q, seen_d;
	logic [ast_pkg::SCORE_W-1:0]   score_q, score_d;
	logic [ast_pkg::TAG_W-1:0]     tags_q, tags_d;

	logic [ast_pkg::STAGE_W-1:0]   target;
	logic                          expired;
	logic                          fast;
	logic [ast_pkg::SCORE_W-1:0]   base;
	logic [ast_pkg::SCORE_W:0]     sum;

	// Timestamps wrap at TIME_BITS.
	generate
		if (TIME_BITS <= ast_pkg::NOW_W) begin : g_now_trunc
			assign now = now_raw[TIME_BITS-1:0];
		end else begin : g_now_ext
			assign now = {{(TIME_BITS-ast_pkg::NOW_W){1'b0}}, now_raw};
		end
	endgenerate

	// Elapsed time, clamped at zero if the clock went backwards.
	function automatic logic [TIME_BITS-1:0] elapsed(input logic [TIME_BITS-1:0] t_now,
		input logic [TIME_BITS-1:0] t_then);
		return (t_now > t_then) ? (t_now - t_then) : '0;
	endfunction

	assign target  = ast_pkg::kind_stage(kind);
	assign expired = (stage_q != ast_pkg::STAGE_IDLE) &&
		(elapsed(now, entry_q) > {{(TIME_BITS-16){1'b0}}, cfg.window_seconds});

	always_comb begin
		stage_d     = stage_q;
		entry_d     = entry_q;
		first_d     = first_q;
		first_vld_d = first_vld_q;
		seen_d      = seen_q;
		tags_d      = tags_q;
		if (expired) begin
			stage_d     = ast_pkg::STAGE_IDLE;
			first_d     = '0;
			first_vld_d = 1'b0;
			seen_d      = '0;
			tags_d      = '0;
		end
		if (!first_vld_d) begin
			first_vld_d = 1'b1;
			first_d     = now;
		end
		if (target > stage_d) begin
			stage_d = target;
			entry_d = now;
		end
		unique case (target)
			ast_pkg::STAGE_RECON:   seen_d[0] = 1'b1;
			ast_pkg::STAGE_EXPLOIT: seen_d[1] = 1'b1;
			ast_pkg::STAGE_EXFIL:   seen_d[2] = 1'b1;
			default: ;
		endcase
		if (seen_d == ast_pkg::ALL_STAGES_SEEN) begin
			stage_d = ast_pkg::STAGE_COMPLETE;
		end
		tags_d = tags_d | ast_pkg::kind_tag(kind);
	end

	always_comb begin
		unique case (stage_d)
			ast_pkg::STAGE_RECON:    base = cfg.score_recon;
			ast_pkg::STAGE_EXPLOIT:  base = cfg.score_exploit;
			ast_pkg::STAGE_EXFIL:    base = cfg.score_exfil;
			ast_pkg::STAGE_COMPLETE: base = cfg.score_complete;
			default:                 base = '0;
		endcase
	end

	assign fast = (stage_d >= ast_pkg::STAGE_EXPLOIT) &&
		(elapsed(now, first_d) < {{(TIME_BITS-16){1'b0}}, cfg.fast_seconds});
	assign sum = {1'b0, base} + (fast ? {1'b0, cfg.speed_bonus} : '0);
	assign score_d = (sum > {1'b0, ast_pkg::SCORE_CAP}) ? ast_pkg::SCORE_CAP
		: sum[ast_pkg::SCORE_W-1:0];

	// A word with no known attack leaves the incident untouched.
	wire logic upd = step && (target != ast_pkg::STAGE_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= ast_pkg::STAGE_IDLE;
			entry_q     <= '0;
			first_q     <= '0;
			first_vld_q <= 1'b0;
			seen_q      <= '0;
			score_q     <= '0;
			tags_q      <= '0;
		end else if (upd) begin
			stage_q     <= stage_d;
			entry_q     <= entry_d;
			first_q     <= first_d;
			first_vld_q <= first_vld_d;
			seen_q      <= seen_d;
			score_q     <= score_d;
			tags_q      <= tags_d;
		end
	end

	always_comb begin
		if (target != ast_pkg::STAGE_IDLE) begin
			res.stage          = stage_d;
			res.severity       = score_d;
			res.stages_seen    = seen_d;
			res.technique_tags = tags_d;
		end else begin
			res.stage          = stage_q;
			res.severity       = score_q;
			res.stages_seen    = seen_q;
			res.technique_tags = tags_q;
		end
	end

endmodule
`default_nettype wire

[rtl/attack_stage_correlator.sv]
// Top level of the attack stage correlator for one tracked source.
// A word is held in the first stage register, and its result word in the result register.
// Throughput: one word per cycle while results drain; the incident state updates
// in the same cycle as the result is formed, so the next word already sees it.
// Reset: arst_n clears the incident, empties both pipeline registers and restores defaults.
`default_nettype none
`include "attack_stage_correlator_macros.svh"
module attack_stage_correlator #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	ast_in_if.sink                                  in_ch,
	ast_out_if.source                               out_ch,
	input  wire logic                               cfg_we,
	input  wire logic [ast_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ast_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	// The block has two register stages. The first captures the detection word as it is
	// accepted. Between the first stage and the result register sits the whole update:
	// kind decode, window expiry check, stage advance, tag merge and score. The incident
	// state is written at the same edge that loads the result register.

	ast_pkg::cfg_t                  cfg;
	ast_pkg::res_t                  res;
	ast_pkg::res_t                  res_q;

	logic                           vld_s1;
	logic [ast_pkg::KIND_W-1:0]     kind_s1;
	logic [ast_pkg::NOW_W-1:0]      now_s1;
	logic                           out_vld_q;
	logic                           advance;
	logic                           in_fire;

	ast_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The first stage moves on whenever the result register is empty or being drained.
	assign advance      = vld_s1 && (!out_vld_q || out_ch.ready);
	assign in_ch.ready  = !vld_s1 || advance;
	assign in_fire      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_fire) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1 <= in_ch.attack_kind;
			now_s1  <= in_ch.now_seconds;
		end
	end

	ast_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.kind    (kind_s1),
		.now_raw (now_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// The result register holds a word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_ch.valid          = out_vld_q;
	assign out_ch.stage          = res_q.stage;
	assign out_ch.severity       = res_q.severity;
	assign out_ch.stages_seen    = res_q.stages_seen;
	assign out_ch.technique_tags = res_q.technique_tags;

	// A complete incident must have seen every stage.
	`AST_ASSERT_SAME(a_complete_all_seen, clk, arst_n,
		out_vld_q && (res_q.stage == ast_pkg::STAGE_COMPLETE),
		res_q.stages_seen == ast_pkg::ALL_STAGES_SEEN)
	// An incident is active exactly when some stage has been seen.
	`AST_ASSERT_SAME(a_active_seen, clk, arst_n, out_vld_q,
		(res_q.stage == ast_pkg::STAGE_IDLE) == (res_q.stages_seen == '0))
	// A word that moves out of the first stage shows up in the result register.
	`AST_ASSERT_NEXT(a_advance_out, clk, arst_n, advance, out_vld_q)

endmodule
`default_nettype wire

[verif/attack_stage_correlator_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the attack stage correlator, driven through its word channels.
module attack_stage_correlator_tb;
	import ast_pkg::*;

	// Kind codes above the last known attack; the block must ignore them.
	localparam logic [KIND_W-1:0] KIND_RESERVED_LO = 4'd11;
	localparam logic [KIND_W-1:0] KIND_RESERVED_HI = 4'd15;
	// A register index past the end of the register list; writes to it are dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	localparam int unsigned PHASE_COUNT    = 6;
	localparam int unsigned PHASE_ITEMS    = 90;
	localparam int unsigned SQUEEZE_CYCLES = 100;
	localparam int unsigned DRAIN_CYCLES   = 4;
	localparam int unsigned WATCHDOG_LIMIT = 1000;

	// The incident tracker keeps its own copy of the registers and of the incident
	// state, works out the report word for every accepted detection word, and
	// checks the report words coming out of the block in order.
	class incident_tracker;
		cfg_t               cfg;
		logic [STAGE_W-1:0] stage;
		logic [NOW_W-1:0]   entry_s;
		logic [NOW_W-1:0]   first_s;
		bit                 first_ok;
		logic [SEEN_W-1:0]  seen;
		logic [SCORE_W-1:0] score;
		logic [TAG_W-1:0]   tags;
		res_t               reports[$];
		int unsigned        errors;

		function new();
			cfg = '{RST_WINDOW, RST_FAST, RST_RECON, RST_EXPLOIT, RST_EXFIL, RST_COMPLETE,
				RST_BONUS};
			stage = STAGE_IDLE;
			entry_s = '0;
			first_s = '0;
			first_ok = 1'b0;
			seen = '0;
			score = '0;
			tags = '0;
			errors = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_WINDOW:   cfg.window_seconds = data;
				CFG_FAST:     cfg.fast_seconds = data;
				CFG_RECON:    cfg.score_recon = data[SCORE_W-1:0];
				CFG_EXPLOIT:  cfg.score_exploit = data[SCORE_W-1:0];
				CFG_EXFIL:    cfg.score_exfil = data[SCORE_W-1:0];
				CFG_COMPLETE: cfg.score_complete = data[SCORE_W-1:0];
				CFG_BONUS:    cfg.speed_bonus = data[SCORE_W-1:0];
				default: ;
			endcase
		endfunction

		// Time that went backwards counts as no time at all.
		function logic [NOW_W-1:0] elapsed(input logic [NOW_W-1:0] now_s,
				input logic [NOW_W-1:0] then_s);
			return (now_s > then_s) ? now_s - then_s : '0;
		endfunction

		function void note_detection(input logic [KIND_W-1:0] kind,
				input logic [NOW_W-1:0] now_s);
			logic [STAGE_W-1:0] target;
			logic [TAG_W-1:0]   tag;
			logic [SCORE_W:0]   total;
			case (kind)
				KIND_PORT_SCAN, KIND_NULL_SCAN, KIND_XMAS_SCAN, KIND_SYNFIN: begin
					target = STAGE_RECON;
					tag = TAG_NET_SCAN;
				end
				KIND_ARP_SPOOF: begin
					target = STAGE_RECON;
					tag = TAG_MITM;
				end
				KIND_SYN_FLOOD: begin
					target = STAGE_EXPLOIT;
					tag = TAG_DOS;
				end
				KIND_BRUTE: begin
					target = STAGE_EXPLOIT;
					tag = TAG_BRUTE;
				end
				KIND_DNS_TUN: begin
					target = STAGE_EXFIL;
					tag = TAG_DNS_EXFIL;
				end
				KIND_AMPLIFY, KIND_ICMP_FLD: begin
					target = STAGE_EXFIL;
					tag = TAG_DOS;
				end
				default: begin
					target = STAGE_IDLE;
					tag = '0;
				end
			endcase
			if (target != STAGE_IDLE) begin
				// A stale incident is dropped before the new detection is applied.
				if (stage != STAGE_IDLE && elapsed(now_s, entry_s) > cfg.window_seconds) begin
					stage = STAGE_IDLE;
					seen = '0;
					first_ok = 1'b0;
					first_s = '0;
					score = '0;
					tags = '0;
				end
				if (!first_ok) begin
					first_ok = 1'b1;
					first_s = now_s;
				end
				if (target > stage) begin
					stage = target;
					entry_s = now_s;
				end
				seen = seen | (SEEN_W'(1) << (target - STAGE_RECON));
				if (seen == ALL_STAGES_SEEN)
					stage = STAGE_COMPLETE;
				tags = tags | tag;
				case (stage)
					STAGE_RECON:    total = {1'b0, cfg.score_recon};
					STAGE_EXPLOIT:  total = {1'b0, cfg.score_exploit};
					STAGE_EXFIL:    total = {1'b0, cfg.score_exfil};
					STAGE_COMPLETE: total = {1'b0, cfg.score_complete};
					default:        total = '0;
				endcase
				if (first_ok && stage >= STAGE_EXPLOIT &&
						elapsed(now_s, first_s) < cfg.fast_seconds)
					total = total + cfg.speed_bonus;
				score = (total > SCORE_CAP) ? SCORE_CAP : total[SCORE_W-1:0];
			end
			reports.push_back({stage, score, seen, tags});
		endfunction

		function void check_report(input res_t got);
			res_t want;
			if (reports.size() == 0) begin
				$error("report word with no detection pending: stage %0d severity %0d",
					got.stage, got.severity);
				errors++;
				return;
			end
			want = reports.pop_front();
			if (got.stage !== want.stage) begin
				$error("stage: expected %0d, actual %0d", want.stage, got.stage);
				errors++;
			end
			if (got.severity !== want.severity) begin
				$error("severity: expected %0d, actual %0d", want.severity, got.severity);
				errors++;
			end
			if (got.stages_seen !== want.stages_seen) begin
				$error("stages_seen: expected %0b, actual %0b", want.stages_seen,
					got.stages_seen);
				errors++;
			end
			if (got.technique_tags !== want.technique_tags) begin
				$error("technique_tags: expected %0b, actual %0b", want.technique_tags,
					got.technique_tags);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return reports.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ast_in_if  in_ch();
	ast_out_if out_ch();

	incident_tracker tracker = new();

	// Running wall clock for the random part, in seconds.
	logic [NOW_W-1:0] epoch_s;
	// While set, neither side inserts idle cycles, so words go back to back.
	bit burst_mode;
	// The stimulus asks once for a long hold-off on the report side; the sink
	// process carries it out and marks it done.
	bit squeeze_req;
	bit squeeze_done;
	int unsigned quiet_cycles = 0;

	attack_stage_correlator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Draws an attack kind that belongs to the given stage.
	function automatic logic [KIND_W-1:0] pick_kind(input logic [STAGE_W-1:0] st);
		case (st)
			STAGE_RECON:   return KIND_W'($urandom_range(KIND_PORT_SCAN, KIND_ARP_SPOOF));
			STAGE_EXPLOIT: return KIND_W'($urandom_range(KIND_SYN_FLOOD, KIND_BRUTE));
			default:       return KIND_W'($urandom_range(KIND_DNS_TUN, KIND_ICMP_FLD));
		endcase
	endfunction

	// Offers one detection word after a random number of idle cycles and waits
	// for the block to take it. Inputs move on the falling edge only.
	task automatic offer_detection(input logic [KIND_W-1:0] kind,
			input logic [NOW_W-1:0] now_s);
		int unsigned gap;
		gap = burst_mode ? 0 : $urandom_range(0, 10);
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.attack_kind <= kind;
		in_ch.now_seconds <= now_s;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		tracker.note_detection(kind, now_s);
	endtask

	// Writes one register; the write lands on the rising edge while cfg_we is held
	// high, and the tracker copy is updated after it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(idx, data);
	endtask

	// Drops the input valid and waits until every report word has come back, so
	// the block is idle before its registers change or the run ends.
	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		cfg_t               settings;
		logic [STAGE_W-1:0] campaign_stage;
		logic [KIND_W-1:0]  kind;
		int unsigned        counted;
		int unsigned        roll;
		int unsigned        span_len;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WINDOW;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.attack_kind = KIND_NONE;
		in_ch.now_seconds = '0;
		epoch_s = '0;
		burst_mode = 1'b0;
		squeeze_req = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, under the reset register values. A no-attack word and an
		// unknown kind before anything happens must report the empty incident.
		offer_detection(KIND_NONE, 32'd0);
		offer_detection(KIND_RESERVED_HI, 32'd5);
		// First activity at time zero has to count as real activity.
		offer_detection(KIND_PORT_SCAN, 32'd0);
		offer_detection(KIND_ARP_SPOOF, 32'd10);
		// Fast move to exploit earns the speed bonus.
		offer_detection(KIND_BRUTE, 32'd100);
		// Time going backwards: no reset, zero elapsed time.
		offer_detection(KIND_SYN_FLOOD, 32'd50);
		// All three stages seen: complete, base plus bonus reaches the cap of 100.
		offer_detection(KIND_DNS_TUN, 32'd200);
		// Exactly the window since the last stage entry keeps the incident alive,
		// one second more clears it.
		offer_detection(KIND_AMPLIFY, 32'd2000);
		offer_detection(KIND_ICMP_FLD, 32'd2001);
		// Exactly the fast time since first activity no longer earns the bonus.
		offer_detection(KIND_SYN_FLOOD, 32'd2301);
		offer_detection(KIND_XMAS_SCAN, 32'd2302);
		offer_detection(KIND_NULL_SCAN, 32'd2303);
		offer_detection(KIND_SYNFIN, 32'd2304);
		for (int k = KIND_RESERVED_LO; k < KIND_RESERVED_HI; k++)
			offer_detection(KIND_W'(k), 32'd2305);
		// The top of the time range, then a step back to zero.
		offer_detection(KIND_PORT_SCAN, 32'hFFFF_FFFF);
		offer_detection(KIND_BRUTE, 32'hFFFF_FFFF);
		offer_detection(KIND_DNS_TUN, 32'd0);

		// Random part in phases, each with its own register settings. The first two
		// phases use the extremes; phase 4 keeps both time limits tiny so that
		// incidents expire and bonuses lapse all the time.
		for (int unsigned phase = 1; phase <= PHASE_COUNT; phase++) begin
			settle();
			settings.window_seconds = 16'($urandom_range(0, 65535));
			settings.fast_seconds = 16'($urandom_range(0, 65535));
			settings.score_recon = SCORE_W'($urandom_range(0, SCORE_CAP));
			settings.score_exploit = SCORE_W'($urandom_range(0, SCORE_CAP));
			settings.score_exfil = SCORE_W'($urandom_range(0, SCORE_CAP));
			settings.score_complete = SCORE_W'($urandom_range(0, SCORE_CAP));
			settings.speed_bonus = SCORE_W'($urandom_range(0, SCORE_CAP));
			case (phase)
				1: settings = '{16'd0, 16'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
				2: settings = '{16'hFFFF, 16'hFFFF, SCORE_CAP, SCORE_CAP, SCORE_CAP, SCORE_CAP,
					SCORE_CAP};
				4: begin
					settings.window_seconds = 16'($urandom_range(0, 20));
					settings.fast_seconds = 16'($urandom_range(0, 20));
				end
				6: begin
					settings.window_seconds = 16'($urandom_range(0, 4000));
					settings.fast_seconds = 16'($urandom_range(0, 4000));
				end
				default: ;
			endcase
			write_reg(CFG_WINDOW, settings.window_seconds);
			write_reg(CFG_FAST, settings.fast_seconds);
			write_reg(CFG_RECON, CFG_DATA_W'(settings.score_recon));
			write_reg(CFG_EXPLOIT, CFG_DATA_W'(settings.score_exploit));
			write_reg(CFG_EXFIL, CFG_DATA_W'(settings.score_exfil));
			write_reg(CFG_COMPLETE, CFG_DATA_W'(settings.score_complete));
			write_reg(CFG_BONUS, CFG_DATA_W'(settings.speed_bonus));
			if (phase == 3)
				write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));

			// Words come in campaigns: mostly a forward walk from recon through
			// exploit to exfil, sometimes out of order, with some noise mixed in.
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				span_len = $urandom_range(1, 8);
				campaign_stage = STAGE_RECON;
				repeat (span_len) begin
					if ($urandom_range(0, 39) == 0)
						burst_mode = !burst_mode;
					if (phase == 3 && counted == 15)
						squeeze_req = 1'b1;

					// Time steps: mostly short, some up to just past the fast limit, some
					// around the window from the last stage entry or the last word, some
					// long jumps, a few of them anywhere in the range, and a few steps back.
					roll = $urandom_range(0, 99);
					if (roll < 40)
						epoch_s = epoch_s + NOW_W'($urandom_range(0, 3));
					else if (roll < 65)
						epoch_s = epoch_s + NOW_W'($urandom_range(0, tracker.cfg.fast_seconds + 2));
					else if (roll < 80)
						epoch_s = ((roll < 72) ? tracker.entry_s : epoch_s) +
							NOW_W'(tracker.cfg.window_seconds) + NOW_W'($urandom_range(0, 2)) - 1;
					else if (roll < 88)
						epoch_s = epoch_s + NOW_W'($urandom_range(0, 200000));
					else if (roll < 95)
						epoch_s = $urandom();
					else
						epoch_s = epoch_s - NOW_W'($urandom_range(1, 5));

					roll = $urandom_range(0, 99);
					if (roll < 10) begin
						if ($urandom_range(0, 5) == 0)
							kind = KIND_NONE;
						else
							kind = KIND_W'($urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI));
					end else if (roll < 85) begin
						kind = pick_kind(campaign_stage);
						if ($urandom_range(0, 1) && campaign_stage != STAGE_EXFIL)
							campaign_stage = campaign_stage + 1'b1;
					end else begin
						kind = pick_kind(STAGE_W'(STAGE_RECON + $urandom_range(0, 2)));
					end
					offer_detection(kind, epoch_s);
					if (kind >= KIND_PORT_SCAN && kind <= KIND_ICMP_FLD)
						counted++;
				end
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Report side: takes each report word after a random hold-off and checks it.
	// Once during the run it holds off for a long stretch while detection words
	// keep coming, which fills the block and must stall its input.
	initial begin : report_sink
		int unsigned hold;
		res_t        got;
		out_ch.ready = 1'b0;
		squeeze_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = burst_mode ? 0 : $urandom_range(0, 10);
			if (squeeze_req && !squeeze_done) begin
				hold = SQUEEZE_CYCLES;
				squeeze_done = 1'b1;
			end
			repeat (hold) begin
				@(negedge clk);
				out_ch.ready <= 1'b0;
			end
			@(negedge clk);
			out_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (out_ch.valid !== 1'b1);
			got = {out_ch.stage, out_ch.severity, out_ch.stages_seen, out_ch.technique_tags};
			tracker.check_report(got);
		end
	end

	// Ends the run if nothing moves on either channel for too long. The longest
	// quiet stretch in a correct run is the long hold-off plus a few idle cycles.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
				(out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
